// ----- rtl/one_wire_bus_master_top_defines.svh -----
// Assertion macros shared by the bus master checker
`ifndef ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define OWBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/owbm_pkg.sv -----
// Types and constants of the single-wire bus master
`timescale 1ns / 1ps
package owbm_pkg;

	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_START  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE = 3'd5;

	localparam logic [9:0] RST_RESET_LOW   = 10'd500;
	localparam logic [7:0] RST_PRES_WAIT   = 8'd38;
	localparam logic [9:0] RST_RECOVERY    = 10'd142;
	localparam logic [7:0] RST_SLOT        = 8'd78;
	localparam logic [3:0] RST_SLOT_START  = 4'd1;
	localparam logic [5:0] RST_READ_SAMPLE = 6'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       line_level;
	} owbm_in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_data;
		logic       rejected;
	} owbm_out_t;

endpackage

// ----- rtl/one_wire_bus_master_top.sv -----
// Byte-level single-wire bus master, top level
//
// Input channel (in_valid / in_stall / in_data): each beat is a command
// (bus reset, write byte, read byte) or a tick that carries the line level
// sampled during that tick. Output channel (out_valid / out_stall /
// out_data): exactly one result beat per input beat, in order, giving the
// line drive for the next tick, busy, done, presence, last read byte and
// a reject flag for a command that arrives while busy.
// The result of an accepted beat is registered and appears in the cycle after.
// Throughput: one beat per cycle when not stalled; the state update is one
// pass of counter compare logic between state and result registers.
// The result register parts the channels: a new beat is taken in the same
// cycle the held result leaves. While the receiver stalls a held result,
// in_stall rises and the input channel waits.
// Configuration: cfg_wr_en with cfg_index and cfg_data writes one timing
// register in a cycle; write only while idle. Indexes past the last
// register are ignored.
// Reset: the bus is idle, the line released, timing registers return to
// their defaults, presence and the read byte clear, no result is pending.
`timescale 1ns / 1ps
module one_wire_bus_master_top import owbm_pkg::*; #(
	parameter int COUNTER_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  owbm_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output owbm_out_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int LW = ((COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W) + 1;
	localparam logic [LW-1:0] CNT_MAX = LW'((1 << COUNTER_BITS) - 1);

	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_RST_LOW     = 3'd1;
	localparam logic [2:0] PH_RST_WAIT    = 3'd2;
	localparam logic [2:0] PH_RST_RECOVER = 3'd3;
	localparam logic [2:0] PH_WRITE       = 3'd4;
	localparam logic [2:0] PH_READ        = 3'd5;

	function automatic logic [LW-1:0] plen(input logic [CFG_W-1:0] r);
		logic [LW-1:0] v;
		begin
			v = (r == '0) ? LW'(1) : LW'(r);
			plen = (v > CNT_MAX) ? CNT_MAX : v;
		end
	endfunction

	logic [9:0] reset_low_q;
	logic [7:0] pres_wait_q;
	logic [9:0] recovery_q;
	logic [7:0] slot_q;
	logic [3:0] slot_start_q;
	logic [5:0] read_sample_q;

	logic [2:0]              phase_q, phase_d;
	logic [COUNTER_BITS-1:0] tick_q, tick_d;
	logic [2:0]              bit_q, bit_d;
	logic [7:0]              shift_q, shift_d;
	logic                    pres_q, pres_d;
	logic [7:0]              last_q, last_d;

	logic                    accept;
	logic                    done;
	logic                    rej;
	logic                    drv;
	logic [COUNTER_BITS-1:0] tick_inc;
	logic [LW-1:0]           tick_inc_w;
	logic [LW-1:0]           pos_w;
	logic [LW-1:0]           slen;
	logic [LW-1:0]           spos;
	logic [LW-1:0]           tick_d_w;

	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q   <= RST_RESET_LOW;
			pres_wait_q   <= RST_PRES_WAIT;
			recovery_q    <= RST_RECOVERY;
			slot_q        <= RST_SLOT;
			slot_start_q  <= RST_SLOT_START;
			read_sample_q <= RST_READ_SAMPLE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RESET_LOW:   reset_low_q   <= cfg_data[9:0];
				REG_PRES_WAIT:   pres_wait_q   <= cfg_data[7:0];
				REG_RECOVERY:    recovery_q    <= cfg_data[9:0];
				REG_SLOT:        slot_q        <= cfg_data[7:0];
				REG_SLOT_START:  slot_start_q  <= cfg_data[3:0];
				REG_READ_SAMPLE: read_sample_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		pres_d     = pres_q;
		last_d     = last_q;
		done       = 1'b0;
		rej        = 1'b0;
		tick_inc   = tick_q + 1'b1;
		tick_inc_w = LW'(tick_inc);
		pos_w      = LW'(tick_q);
		slen       = plen(CFG_W'(slot_q));
		spos       = (LW'(read_sample_q) < slen) ? LW'(read_sample_q) : slen - 1'b1;

		if (in_data.opcode == OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				tick_d = tick_inc;
				case (phase_q)
					PH_RST_LOW: begin
						if (tick_inc_w >= plen(reset_low_q)) begin
							phase_d = PH_RST_WAIT;
							tick_d  = '0;
						end
					end
					PH_RST_WAIT: begin
						if (tick_inc_w >= plen(CFG_W'(pres_wait_q))) begin
							pres_d  = !in_data.line_level;
							phase_d = PH_RST_RECOVER;
							tick_d  = '0;
						end
					end
					PH_RST_RECOVER: begin
						if (tick_inc_w >= plen(recovery_q)) begin
							phase_d = PH_IDLE;
							tick_d  = '0;
							done    = 1'b1;
						end
					end
					PH_WRITE, PH_READ: begin
						if (phase_q == PH_READ && pos_w == spos) begin
							shift_d = {in_data.line_level, shift_q[7:1]};
						end
						if (tick_inc_w >= slen) begin
							tick_d = '0;
							if (phase_q == PH_WRITE) begin
								shift_d = {1'b0, shift_q[7:1]};
							end
							if (bit_q == 3'd7) begin
								if (phase_q == PH_READ) begin
									last_d = shift_d;
								end
								phase_d = PH_IDLE;
								bit_d   = '0;
								done    = 1'b1;
							end else begin
								bit_d = bit_q + 1'b1;
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
						tick_d  = '0;
					end
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			rej = 1'b1;
		end else begin
			tick_d = '0;
			bit_d  = '0;
			case (in_data.opcode)
				OP_RESET: phase_d = PH_RST_LOW;
				OP_WRITE: begin
					phase_d = PH_WRITE;
					shift_d = in_data.data_byte;
				end
				OP_READ: begin
					phase_d = PH_READ;
					shift_d = '0;
				end
				default: ;
			endcase
		end

		tick_d_w = LW'(tick_d);
		case (phase_d)
			PH_RST_LOW: drv = 1'b1;
			PH_WRITE:   drv = (tick_d_w < LW'(slot_start_q)) ||
					(!shift_d[0] && (tick_d_w + 1'b1 < slen));
			PH_READ:    drv = tick_d_w < LW'(slot_start_q);
			default:    drv = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			last_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data.drive_low <= drv;
			out_data.busy_res  <= (phase_d != PH_IDLE);
			out_data.done_res  <= done;
			out_data.presence  <= pres_d;
			out_data.read_data <= last_d;
			out_data.rejected  <= rej;
		end
	end

endmodule

// ----- rtl/owbm_checker.sv -----
// Port-level assertions for the bus master and their bind
`timescale 1ns / 1ps
`include "one_wire_bus_master_top_defines.svh"
module owbm_checker import owbm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input owbm_out_t out_data
);

	`OWBM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
	`OWBM_ASSERT_NOW(a_done_idle, clk, arst_n, out_valid && out_data.done_res, !out_data.busy_res, "done reported while still busy")
	`OWBM_ASSERT_NOW(a_reject_busy, clk, arst_n, out_valid && out_data.rejected, out_data.busy_res, "command rejected while idle")
	`OWBM_ASSERT_NOW(a_drive_busy, clk, arst_n, out_valid && out_data.drive_low, out_data.busy_res, "line driven low while idle")
	`OWBM_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled with no held result")

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (.*);

// ----- tb/owbm_tb_pkg.sv -----
// Bus master response predictor and result scoreboard
`timescale 1ns / 1ps
package owbm_tb_pkg;
	import owbm_pkg::*;

	localparam int CNT_BITS = 10;
	localparam int unsigned CNT_MAX = (1 << CNT_BITS) - 1;

	typedef enum logic [2:0] {
		BUS_IDLE,
		BUS_RST_LOW,
		BUS_RST_WAIT,
		BUS_RST_RECOVER,
		BUS_WRITE,
		BUS_READ
	} bus_phase_e;

	class bus_master_scoreboard;
		logic [9:0] reset_low;
		logic [7:0] pres_wait;
		logic [9:0] recovery;
		logic [7:0] slot_len;
		logic [3:0] slot_start;
		logic [5:0] read_sample;
		bus_phase_e phase;
		int unsigned pos;
		logic [2:0] bit_num;
		logic [7:0] shifter;
		logic pres_flag;
		logic [7:0] last_byte;
		owbm_out_t due_responses[$];
		int errors;

		function new();
			reset_low = RST_RESET_LOW;
			pres_wait = RST_PRES_WAIT;
			recovery = RST_RECOVERY;
			slot_len = RST_SLOT;
			slot_start = RST_SLOT_START;
			read_sample = RST_READ_SAMPLE;
			phase = BUS_IDLE;
			pos = 0;
			bit_num = '0;
			shifter = '0;
			pres_flag = 1'b0;
			last_byte = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_RESET_LOW: reset_low = data[9:0];
				REG_PRES_WAIT: pres_wait = data[7:0];
				REG_RECOVERY: recovery = data[9:0];
				REG_SLOT: slot_len = data[7:0];
				REG_SLOT_START: slot_start = data[3:0];
				REG_READ_SAMPLE: read_sample = data[5:0];
				default: ;
			endcase
		endfunction

		function bit busy();
			return phase != BUS_IDLE;
		endfunction

		function int pending();
			return due_responses.size();
		endfunction

		function int unsigned span(int unsigned v);
			if (v == 0)
				return 1;
			return (v > CNT_MAX) ? CNT_MAX : v;
		endfunction

		function logic line_drive();
			int unsigned slen;
			slen = span(slot_len);
			case (phase)
				BUS_RST_LOW: return 1'b1;
				BUS_WRITE: return (pos < slot_start) || (!shifter[0] && pos + 1 < slen);
				BUS_READ: return pos < slot_start;
				default: return 1'b0;
			endcase
		endfunction

		function bit advance(logic line);
			int unsigned slen;
			int unsigned prior;
			int unsigned spos;
			slen = span(slot_len);
			prior = pos;
			pos = (pos + 1) & CNT_MAX;
			case (phase)
				BUS_RST_LOW: begin
					if (pos >= span(reset_low)) begin
						phase = BUS_RST_WAIT;
						pos = 0;
					end
				end
				BUS_RST_WAIT: begin
					if (pos >= span(pres_wait)) begin
						pres_flag = !line;
						phase = BUS_RST_RECOVER;
						pos = 0;
					end
				end
				BUS_RST_RECOVER: begin
					if (pos >= span(recovery)) begin
						phase = BUS_IDLE;
						pos = 0;
						return 1'b1;
					end
				end
				BUS_WRITE, BUS_READ: begin
					spos = (read_sample < slen) ? read_sample : slen - 1;
					if (phase == BUS_READ && prior == spos)
						shifter = {line, shifter[7:1]};
					if (pos < slen)
						return 1'b0;
					pos = 0;
					if (phase == BUS_WRITE)
						shifter = shifter >> 1;
					if (bit_num == 3'd7) begin
						if (phase == BUS_READ)
							last_byte = shifter;
						phase = BUS_IDLE;
						bit_num = '0;
						return 1'b1;
					end
					bit_num = bit_num + 3'd1;
				end
				default: begin
					phase = BUS_IDLE;
					pos = 0;
				end
			endcase
			return 1'b0;
		endfunction

		function void note_beat(owbm_in_t b);
			owbm_out_t r;
			logic done;
			logic rej;
			done = 1'b0;
			rej = 1'b0;
			if (b.opcode == OP_TICK) begin
				if (busy())
					done = advance(b.line_level);
			end else if (busy()) begin
				rej = 1'b1;
			end else begin
				pos = 0;
				bit_num = '0;
				case (b.opcode)
					OP_RESET: phase = BUS_RST_LOW;
					OP_WRITE: begin
						phase = BUS_WRITE;
						shifter = b.data_byte;
					end
					default: begin
						phase = BUS_READ;
						shifter = '0;
					end
				endcase
			end
			r.drive_low = line_drive();
			r.busy_res = busy();
			r.done_res = done;
			r.presence = pres_flag;
			r.read_data = last_byte;
			r.rejected = rej;
			due_responses.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_response(owbm_out_t got);
			owbm_out_t want;
			if (due_responses.size() == 0) begin
				report($sformatf("result beat %h with none expected", got));
				return;
			end
			want = due_responses.pop_front();
			if (got.drive_low !== want.drive_low)
				report($sformatf("drive_low %b, want %b", got.drive_low, want.drive_low));
			if (got.busy_res !== want.busy_res)
				report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
			if (got.done_res !== want.done_res)
				report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
			if (got.presence !== want.presence)
				report($sformatf("presence %b, want %b", got.presence, want.presence));
			if (got.read_data !== want.read_data)
				report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
			if (got.rejected !== want.rejected)
				report($sformatf("rejected %b, want %b", got.rejected, want.rejected));
		endtask
	endclass

endpackage

// ----- tb/tb.sv -----
// Top-level testbench of the single-wire bus master
`timescale 1ns / 1ps
module tb;
	import owbm_pkg::*;
	import owbm_tb_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	owbm_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	owbm_out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	int send_pct = 0;
	int recv_pct = 0;
	int quiet_cycles = 0;
	bus_master_scoreboard sb = new();

	one_wire_bus_master_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_response(out_data);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic owbm_in_t make_beat(logic [1:0] op);
		owbm_in_t b;
		b.opcode = op;
		b.data_byte = 8'($urandom);
		b.line_level = 1'($urandom_range(1));
		return b;
	endfunction

	function automatic logic [1:0] pick_command();
		case ($urandom_range(2))
			0: return OP_RESET;
			1: return OP_WRITE;
			default: return OP_READ;
		endcase
	endfunction

	task automatic send_beat(owbm_in_t b);
		int gap;
		gap = ($urandom_range(99) < send_pct) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		sb.note_beat(b);
	endtask

	task automatic run_op(logic [1:0] op, logic [7:0] data);
		owbm_in_t b;
		b = make_beat(op);
		b.data_byte = data;
		send_beat(b);
		while (sb.busy())
			send_beat(make_beat(OP_TICK));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic write_timing(int rl, int pw, int rc, int sl, int ss, int rs);
		write_reg(REG_RESET_LOW, CFG_W'(rl));
		write_reg(REG_PRES_WAIT, CFG_W'(pw));
		write_reg(REG_RECOVERY, CFG_W'(rc));
		write_reg(REG_SLOT, CFG_W'(sl));
		write_reg(REG_SLOT_START, CFG_W'(ss));
		write_reg(REG_READ_SAMPLE, CFG_W'(rs));
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_timing();
		int ss;
		int rs;
		ss = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
		rs = ($urandom_range(3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
		write_timing($urandom_range(0, 12), $urandom_range(0, 10), $urandom_range(0, 12),
			$urandom_range(0, 10), ss, rs);
	endtask

	task automatic random_traffic(int n);
		int counted;
		logic [1:0] op;
		bit counts;
		counted = 0;
		while (counted < n || sb.busy()) begin
			if (sb.busy())
				op = ($urandom_range(99) < 5) ? pick_command() : OP_TICK;
			else
				op = ($urandom_range(99) < 90) ? pick_command() : OP_TICK;
			counts = (op == OP_TICK) ? sb.busy() : !sb.busy();
			send_beat(make_beat(op));
			if (counts)
				counted++;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pct = 15;
		recv_pct = 57;
		send_beat(make_beat(OP_TICK));
		send_beat(make_beat(OP_TICK));
		send_beat(make_beat(OP_RESET));
		send_beat(make_beat(OP_RESET));
		send_beat(make_beat(OP_WRITE));
		send_beat(make_beat(OP_READ));
		while (sb.busy())
			send_beat(make_beat(OP_TICK));

		settle();
		write_timing(0, 0, 0, 0, 0, 0);
		run_op(OP_RESET, 8'h00);
		run_op(OP_WRITE, 8'h00);
		run_op(OP_READ, 8'hFF);

		settle();
		write_reg(REG_UNUSED_LO, CFG_W'($urandom));
		write_reg(REG_UNUSED_HI, CFG_W'($urandom));
		write_timing(2, 1, 2, 4, 15, 63);
		run_op(OP_WRITE, 8'h5A);
		run_op(OP_READ, 8'h00);
		run_op(OP_RESET, 8'h00);

		settle();
		write_timing(1, 1, 1, 4, 1, 1);
		run_op(OP_WRITE, 8'hA5);
		run_op(OP_READ, 8'h00);
		run_op(OP_RESET, 8'h00);

		for (int mode = 0; mode < 3; mode++) begin
			send_pct = (mode == 0) ? 15 : (mode == 1) ? 57 : 0;
			recv_pct = (mode == 0) ? 57 : (mode == 1) ? 15 : 0;
			for (int k = 0; k < 2; k++) begin
				settle();
				random_timing();
				random_traffic(40);
			end
		end

		settle();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
